// ===== sv/sm4_pkg.sv =====
// ----------------------------------------------------------------------------
// sm4_pkg
// Shared constants, types and round functions of the SM4 block cipher.
// ----------------------------------------------------------------------------
package sm4_pkg;

  // Cipher geometry
  localparam int ROUNDS = 32;
  localparam int WORD_W = 32;
  localparam int HALF_W = 64;

  // Configuration register indexes
  localparam int CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] REG_KEY_HIGH = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_KEY_LOW  = 1'b1;

  // Transaction commands
  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  // System parameter FK, xored into the key words before expansion
  localparam logic [WORD_W-1:0] FK [4] = '{
    32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc
  };

  // Substitution box
  localparam logic [7:0] SBOX [256] = '{
    8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7,
    8'h16, 8'hb6, 8'h14, 8'hc2, 8'h28, 8'hfb, 8'h2c, 8'h05,
    8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
    8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
    8'h9c, 8'h42, 8'h50, 8'hf4, 8'h91, 8'hef, 8'h98, 8'h7a,
    8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
    8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95,
    8'h80, 8'hdf, 8'h94, 8'hfa, 8'h75, 8'h8f, 8'h3f, 8'ha6,
    8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
    8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8,
    8'h68, 8'h6b, 8'h81, 8'hb2, 8'h71, 8'h64, 8'hda, 8'h8b,
    8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
    8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2,
    8'h25, 8'h22, 8'h7c, 8'h3b, 8'h01, 8'h21, 8'h78, 8'h87,
    8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
    8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e,
    8'hea, 8'hbf, 8'h8a, 8'hd2, 8'h40, 8'hc7, 8'h38, 8'hb5,
    8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
    8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55,
    8'had, 8'h93, 8'h32, 8'h30, 8'hf5, 8'h8c, 8'hb1, 8'he3,
    8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
    8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f,
    8'hd5, 8'hdb, 8'h37, 8'h45, 8'hde, 8'hfd, 8'h8e, 8'h2f,
    8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
    8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f,
    8'h11, 8'hd9, 8'h5c, 8'h41, 8'h1f, 8'h10, 8'h5a, 8'hd8,
    8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
    8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0,
    8'h89, 8'h69, 8'h97, 8'h4a, 8'h0c, 8'h96, 8'h77, 8'h7e,
    8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
    8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20,
    8'h79, 8'hee, 8'h5f, 8'h3e, 8'hd7, 8'hcb, 8'h39, 8'h48
  };

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_CRYPT,
    ST_DONE
  } sm4_state_t;

  // Controls from the sequencer to the datapath
  typedef struct packed {
    logic load_blk;
    logic load_key;
    logic step;
    logic key_mode;
  } sm4_dp_ctrl_t;

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] b, input int n);
    return (b << n) | (b >> (WORD_W - n));
  endfunction

  // Byte-wise S-box substitution of one word
  function automatic logic [WORD_W-1:0] sub_word(input logic [WORD_W-1:0] x);
    return {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
  endfunction

  // Linear transform L of the data rounds
  function automatic logic [WORD_W-1:0] lin_data(input logic [WORD_W-1:0] b);
    return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
  endfunction

  // Linear transform L' of the key schedule
  function automatic logic [WORD_W-1:0] lin_key(input logic [WORD_W-1:0] b);
    return b ^ rotl(b, 13) ^ rotl(b, 23);
  endfunction

  // CK word of round idx: byte j is (4*idx + j) * 7 mod 256
  function automatic logic [WORD_W-1:0] round_const(input logic [7:0] idx);
    logic [7:0] base;
    base = idx * 8'd28;
    return {base, base + 8'd7, base + 8'd14, base + 8'd21};
  endfunction

endpackage

// ===== sv/sm4_ifs.sv =====
// ----------------------------------------------------------------------------
// sm4 channel interfaces
// Valid/ready channels that carry block transactions in and results out.
// ----------------------------------------------------------------------------

// Block channel: command and 128-bit block
interface sm4_in_if;
  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic [sm4_pkg::HALF_W-1:0] block_high;
  logic [sm4_pkg::HALF_W-1:0] block_low;

  modport source (output valid, output cmd, output block_high, output block_low,
                  input ready);
  modport sink (input valid, input cmd, input block_high, input block_low,
                output ready);
endinterface

// Result channel: 128-bit block
interface sm4_out_if;
  logic                      valid;
  logic                      ready;
  logic [sm4_pkg::HALF_W-1:0] result_high;
  logic [sm4_pkg::HALF_W-1:0] result_low;

  modport source (output valid, output result_high, output result_low, input ready);
  modport sink (input valid, input result_high, input result_low, output ready);
endinterface

// ===== sv/sm4_block_cipher.sv =====
// Timing: the accepting edge loads the block, the rounds run in ST_CRYPT, and ST_DONE
// loads the output register once it is free; the round keys are first expanded in
// ST_EXPAND after reset or a key write. Blocks: one at a time, through the 32 rounds
// of the single round unit, each reading one round key from the key RAM.
// Reset: synchronous, active low; key registers clear to zero and the round keys are
// marked stale, so the first block waits for a fresh expansion.
// ----------------------------------------------------------------------------
// sm4_block_cipher
// SM4 encrypt/decrypt engine: key registers, round-key RAM, sequencer and
// output register around a shared round datapath.
// ----------------------------------------------------------------------------
module sm4_block_cipher #(
  parameter int ROUNDS = sm4_pkg::ROUNDS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  sm4_in_if.sink                           in_ch,
  sm4_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [sm4_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [sm4_pkg::HALF_W-1:0]       cfg_wdata
);

  localparam int RndW = $clog2(ROUNDS);
  localparam logic [RndW-1:0] LastRnd = RndW'(ROUNDS - 1);

  sm4_pkg::sm4_state_t        state_r, state_nxt;
  logic [RndW-1:0]            rnd_r, rnd_nxt;
  logic                       keys_ready_r, keys_ready_nxt;
  logic                       dec_r, dec_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [sm4_pkg::HALF_W-1:0] key_high_r, key_low_r;
  logic [sm4_pkg::HALF_W-1:0] res_high_r, res_low_r;
  logic                       res_load;
  logic [RndW-1:0]            rnd_inc;

  sm4_pkg::sm4_dp_ctrl_t      ctrl;
  logic                       ram_we;
  logic                       ram_re;
  logic [RndW-1:0]            ram_raddr;
  logic [sm4_pkg::WORD_W-1:0] rk;
  logic [sm4_pkg::WORD_W-1:0] new_word;
  logic [sm4_pkg::HALF_W-1:0] dp_high, dp_low;
  logic                       in_acc;

  // Accept blocks only when idle, with fresh round keys and no key write in flight
  assign in_ch.ready = (state_r == sm4_pkg::ST_IDLE) && keys_ready_r && !cfg_we;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign rnd_inc     = rnd_r + 1'b1;

  // Key registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        sm4_pkg::REG_KEY_HIGH: key_high_r <= cfg_wdata;
        sm4_pkg::REG_KEY_LOW:  key_low_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequencer: next state and datapath controls
  always_comb begin
    state_nxt      = state_r;
    rnd_nxt        = rnd_r;
    keys_ready_nxt = keys_ready_r;
    dec_nxt        = dec_r;
    ctrl           = '0;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_raddr      = rnd_r;
    res_load       = 1'b0;
    case (state_r)
      sm4_pkg::ST_IDLE: begin
        if (!keys_ready_r && !cfg_we) begin
          ctrl.load_key = 1'b1;
          rnd_nxt       = '0;
          state_nxt     = sm4_pkg::ST_EXPAND;
        end else if (in_acc) begin
          ctrl.load_blk = 1'b1;
          dec_nxt       = in_ch.cmd;
          rnd_nxt       = '0;
          ram_re        = 1'b1;
          ram_raddr     = (in_ch.cmd == sm4_pkg::CMD_DECRYPT) ? LastRnd : '0;
          state_nxt     = sm4_pkg::ST_CRYPT;
        end
      end
      sm4_pkg::ST_EXPAND: begin
        ctrl.step     = 1'b1;
        ctrl.key_mode = 1'b1;
        ram_we        = 1'b1;
        if (cfg_we) begin
          // drop the stale expansion and restart from the new key
          state_nxt = sm4_pkg::ST_IDLE;
        end else if (rnd_r == LastRnd) begin
          keys_ready_nxt = 1'b1;
          state_nxt      = sm4_pkg::ST_IDLE;
        end else begin
          rnd_nxt = rnd_inc;
        end
      end
      sm4_pkg::ST_CRYPT: begin
        ctrl.step = 1'b1;
        ram_re    = 1'b1;
        ram_raddr = (dec_r == sm4_pkg::CMD_DECRYPT) ? LastRnd - rnd_inc : rnd_inc;
        if (rnd_r == LastRnd) begin
          state_nxt = sm4_pkg::ST_DONE;
        end else begin
          rnd_nxt = rnd_inc;
        end
      end
      sm4_pkg::ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          res_load  = 1'b1;
          state_nxt = sm4_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sm4_pkg::ST_IDLE;
    endcase
    // a key write always invalidates the round keys
    if (cfg_we) begin
      keys_ready_nxt = 1'b0;
    end
  end

  // Output register valid: set on load, clear when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= sm4_pkg::ST_IDLE;
      rnd_r        <= '0;
      keys_ready_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rnd_r        <= rnd_nxt;
      keys_ready_r <= keys_ready_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    dec_r <= dec_nxt;
    if (res_load) begin
      res_high_r <= dp_high;
      res_low_r  <= dp_low;
    end
  end

  // Round key store
  sm4_ram #(
    .Width (sm4_pkg::WORD_W),
    .Depth (ROUNDS)
  ) u_rk_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (rnd_r),
    .wdata (new_word),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rk)
  );

  sm4_datapath #(
    .RndW (RndW)
  ) u_dp (
    .clk         (clk),
    .ctrl        (ctrl),
    .rnd         (rnd_r),
    .key_high    (key_high_r),
    .key_low     (key_low_r),
    .block_high  (in_ch.block_high),
    .block_low   (in_ch.block_low),
    .rk          (rk),
    .new_word    (new_word),
    .result_high (dp_high),
    .result_low  (dp_low)
  );

  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_high = res_high_r;
  assign out_ch.result_low  = res_low_r;

endmodule

// ===== sv/sm4_ram.sv =====
// ----------------------------------------------------------------------------
// sm4_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module sm4_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/sm4_datapath.sv =====
// ----------------------------------------------------------------------------
// sm4_datapath
// Four-word state register and one shared round unit, used both for key
// expansion (CK, L') and for the data rounds (round key, L).
// ----------------------------------------------------------------------------
module sm4_datapath #(
  parameter int RndW = 5
) (
  input  logic                         clk,
  input  sm4_pkg::sm4_dp_ctrl_t        ctrl,
  input  logic [RndW-1:0]              rnd,
  input  logic [sm4_pkg::HALF_W-1:0]   key_high,
  input  logic [sm4_pkg::HALF_W-1:0]   key_low,
  input  logic [sm4_pkg::HALF_W-1:0]   block_high,
  input  logic [sm4_pkg::HALF_W-1:0]   block_low,
  input  logic [sm4_pkg::WORD_W-1:0]   rk,
  output logic [sm4_pkg::WORD_W-1:0]   new_word,
  output logic [sm4_pkg::HALF_W-1:0]   result_high,
  output logic [sm4_pkg::HALF_W-1:0]   result_low
);

  logic [sm4_pkg::WORD_W-1:0] x_r   [4];
  logic [sm4_pkg::WORD_W-1:0] x_nxt [4];
  logic [sm4_pkg::WORD_W-1:0] mix;
  logic [sm4_pkg::WORD_W-1:0] subst;
  logic [7:0]                 rnd_byte;

  assign rnd_byte = 8'(rnd);

  // One round: mix three words with a round key or CK, substitute, diffuse
  always_comb begin
    mix = x_r[1] ^ x_r[2] ^ x_r[3] ^
          (ctrl.key_mode ? sm4_pkg::round_const(rnd_byte) : rk);
    subst = sm4_pkg::sub_word(mix);
    new_word = x_r[0] ^ (ctrl.key_mode ? sm4_pkg::lin_key(subst)
                                       : sm4_pkg::lin_data(subst));
  end

  // Load a key or a block, or advance the word window by one round
  always_comb begin
    x_nxt = x_r;
    if (ctrl.load_key) begin
      x_nxt[0] = key_high[63:32] ^ sm4_pkg::FK[0];
      x_nxt[1] = key_high[31:0]  ^ sm4_pkg::FK[1];
      x_nxt[2] = key_low[63:32]  ^ sm4_pkg::FK[2];
      x_nxt[3] = key_low[31:0]   ^ sm4_pkg::FK[3];
    end else if (ctrl.load_blk) begin
      x_nxt[0] = block_high[63:32];
      x_nxt[1] = block_high[31:0];
      x_nxt[2] = block_low[63:32];
      x_nxt[3] = block_low[31:0];
    end else if (ctrl.step) begin
      x_nxt[0] = x_r[1];
      x_nxt[1] = x_r[2];
      x_nxt[2] = x_r[3];
      x_nxt[3] = new_word;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
  end

  // Final words leave in reverse order
  assign result_high = {x_r[3], x_r[2]};
  assign result_low  = {x_r[1], x_r[0]};

endmodule

// ===== sv/sm4_checker.sv =====
// ----------------------------------------------------------------------------
// sm4_checker
// Port-level assertions for the SM4 engine, bound to the top level.
// ----------------------------------------------------------------------------
module sm4_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic cfg_we
);

  // Hold a pending result until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before being taken");

  // One block at a time: no new transaction right after one is taken
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("block accepted while engine busy");

  // A key write forces a new expansion before the next block
  a_key_stale: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ready)
    else $error("block accepted with stale round keys");

  // Reset empties the output register
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sm4_block_cipher sm4_checker u_sm4_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .cfg_we    (cfg_we)
);
